// File: rtl/base64_stream_encoder_core_assert.svh
// ----------------------------------------------------------------------------
// base64 stream encoder assertion macros
// Concurrent assertion wrappers shared by the encoder RTL.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_ENCODER_CORE_ASSERT_SVH
`define BASE64_STREAM_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define B64E_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked through reset as well.
`define B64E_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the character table of the base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

    localparam int unsigned B64E_QUEUE_DEPTH = 2;

    localparam logic [7:0] B64E_PAD_CHAR = 8'h3D;

    localparam logic [1:0] PADS_NONE = 2'd0;
    localparam logic [1:0] PADS_ONE  = 2'd1;
    localparam logic [1:0] PADS_TWO  = 2'd2;

    // Bytes already held in the current 3-byte group.
    typedef enum logic [1:0] {
        POS_START = 2'd0,
        POS_ONE   = 2'd1,
        POS_TWO   = 2'd2
    } t_gpos;

    // One finished group: four sextets, how many trail as '=', closes message.
    typedef struct packed {
        logic [3:0][5:0] sext;
        logic [1:0]      pads;
        logic            last;
    } t_group;

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v - 6'd26};
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v - 6'd52};
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

// File: rtl/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Accepts message bytes, tracks the group position and packs full or
// padded groups into sextets for the group queue.
// ----------------------------------------------------------------------------
module b64e_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_data_byte,
    input  logic                i_end_of_message,
    input  logic                i_full,
    output logic                o_push,
    output b64e_pkg::t_group    o_group
);

    b64e_pkg::t_gpos r_pos;
    b64e_pkg::t_gpos n_pos;
    logic [7:0]      r_b0;
    logic [7:0]      r_b1;
    logic            accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        n_pos = r_pos;
        if (accept) begin
            unique case (r_pos)
                b64e_pkg::POS_ONE: begin
                    n_pos = i_end_of_message ? b64e_pkg::POS_START : b64e_pkg::POS_TWO;
                end
                b64e_pkg::POS_TWO: begin
                    n_pos = b64e_pkg::POS_START;
                end
                default: begin
                    n_pos = i_end_of_message ? b64e_pkg::POS_START : b64e_pkg::POS_ONE;
                end
            endcase
        end
    end

    always_comb begin
        o_push  = 1'b0;
        o_group = '0;
        if (accept) begin
            unique case (r_pos)
                b64e_pkg::POS_ONE: begin
                    o_push          = i_end_of_message;
                    o_group.sext[0] = r_b0[7:2];
                    o_group.sext[1] = {r_b0[1:0], i_data_byte[7:4]};
                    o_group.sext[2] = {i_data_byte[3:0], 2'b00};
                    o_group.pads    = b64e_pkg::PADS_ONE;
                    o_group.last    = 1'b1;
                end
                b64e_pkg::POS_TWO: begin
                    o_push          = 1'b1;
                    o_group.sext[0] = r_b0[7:2];
                    o_group.sext[1] = {r_b0[1:0], r_b1[7:4]};
                    o_group.sext[2] = {r_b1[3:0], i_data_byte[7:6]};
                    o_group.sext[3] = i_data_byte[5:0];
                    o_group.pads    = b64e_pkg::PADS_NONE;
                    o_group.last    = i_end_of_message;
                end
                default: begin
                    o_push          = i_end_of_message;
                    o_group.sext[0] = i_data_byte[7:2];
                    o_group.sext[1] = {i_data_byte[1:0], 4'b0000};
                    o_group.pads    = b64e_pkg::PADS_TWO;
                    o_group.last    = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= b64e_pkg::POS_START;
        end else begin
            r_pos <= n_pos;
        end
    end

    // Hold pending bytes; the group position decides which slot they fill.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (r_pos == b64e_pkg::POS_ONE) begin
                r_b1 <= i_data_byte;
            end else if (r_pos != b64e_pkg::POS_TWO) begin
                r_b0 <= i_data_byte;
            end
        end
    end

endmodule

// File: rtl/b64e_queue.sv
// ----------------------------------------------------------------------------
// b64e_queue
// Short queue of packed groups between the byte front and the character back.
// ----------------------------------------------------------------------------
module b64e_queue #(
    parameter int unsigned DEPTH = b64e_pkg::B64E_QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  b64e_pkg::t_group    i_group,
    output logic                o_full,
    input  logic                i_pop,
    output b64e_pkg::t_group    o_group,
    output logic                o_empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    b64e_pkg::t_group r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_group = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_group;
        end
    end

endmodule

// File: rtl/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Takes groups from the queue and sends their four characters one beat
// at a time through a registered output.
// ----------------------------------------------------------------------------
module b64e_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  b64e_pkg::t_group    i_group,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_out_char,
    output logic                o_last_char
);

    b64e_pkg::t_group r_grp;
    logic             r_busy;
    logic [1:0]       r_idx;
    logic             r_out_valid;
    logic [7:0]       r_out_char;
    logic             r_out_last;
    logic             out_free;
    logic             send;
    logic             final_char;
    logic             pad_here;
    logic [7:0]       cur_char;

    assign out_free   = !r_out_valid || i_ready;
    assign send       = r_busy && out_free;
    assign final_char = (r_idx == 2'd3);
    // Refill when idle or while the last character of this group goes out.
    assign o_pop      = !i_empty && (!r_busy || (send && final_char));

    assign pad_here = ((r_grp.pads == b64e_pkg::PADS_TWO) && r_idx[1])
                   || ((r_grp.pads == b64e_pkg::PADS_ONE) && final_char);
    assign cur_char = pad_here ? b64e_pkg::B64E_PAD_CHAR
                               : b64e_pkg::sextet_char(r_grp.sext[r_idx]);

    assign o_valid     = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last_char = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (send) begin
                r_idx <= r_idx + 1'b1;
                if (final_char) begin
                    r_busy <= 1'b0;
                end
            end
            if (send) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_grp <= i_group;
        end
        if (send) begin
            r_out_char <= cur_char;
            r_out_last <= r_grp.last && final_char;
        end
    end

endmodule

// File: rtl/base64_stream_encoder_core.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder_core
// Streaming base64 encoder, standard alphabet with '=' padding.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_ready  | i_data_byte, i_end_of_message
//  output  | out       | o_valid / i_ready  | o_out_char, o_last_char
//
//  A byte is taken whenever the group queue has room; a byte that
//  completes or ends a group is packed into the queue in the cycle it is taken.
//  Each group leaves as four beats, one per cycle while i_ready does not
//  stall the output, through the one-character output register.
//  Reset (synchronous, active low) clears group position, queue and output.
//  Output stalls back up through the queue to o_ready; input gaps do not
//  stop characters already queued.
// ----------------------------------------------------------------------------
`include "base64_stream_encoder_core_assert.svh"

module base64_stream_encoder_core #(
    parameter int unsigned QUEUE_DEPTH = b64e_pkg::B64E_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_char,
    output logic        o_last_char
);

    b64e_pkg::t_group push_group;
    b64e_pkg::t_group head_group;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;

    b64e_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .i_full           (full),
        .o_push           (push),
        .o_group          (push_group)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_group (push_group),
        .o_full  (full),
        .i_pop   (pop),
        .o_group (head_group),
        .o_empty (empty)
    );

    b64e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_group     (head_group),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char)
    );

    `B64E_ASSERT_NOW(a_no_push_when_full, push, !full, "group pushed into full queue")
    `B64E_ASSERT_NOW(a_no_pop_when_empty, pop, !empty, "group popped from empty queue")
    `B64E_ASSERT_NEXT(a_reset_clears, !i_rst_n, !o_valid && empty, "reset left state behind")

endmodule
